FILE: sv/gap_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the global average pooling block.
// No dependencies; every other file but the two interfaces depends on this package.
package gap_pkg;

   // Width of the slice length register, fixed by the register map.
   localparam int CSR_BITS = 17;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_ABS,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   // Requests into the divider.
   typedef struct packed {
      logic start;
      logic out_free;
   } div_ctl_type;

   // Status out of the divider.
   typedef struct packed {
      logic idle;
      logic done;
   } div_stat_type;

endpackage

FILE: sv/gap_req_if.sv
`timescale 1ns / 1ps
// Sample channel of the pooling block: valid/ready handshake plus one sample.
// Stands alone; no package needed.
interface gap_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: sv/gap_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the pooling block: valid/ready handshake plus one average.
// Stands alone; no package needed.
interface gap_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

FILE: sv/gap_acc.sv
`timescale 1ns / 1ps
// Running sum and slice position counter; flags the last sample of a slice.
// Depends on gap_pkg.
module gap_acc #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_LEN     = 65536,
   parameter int LEN_W       = 17,
   parameter int SUM_W       = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [gap_pkg::CSR_BITS-1:0]  count_reg,
   output logic                          slice_end,
   output logic signed [SUM_W-1:0]       sum_total,
   output logic [LEN_W-1:0]              len
);
   import gap_pkg::*;

   localparam int CW = (CSR_BITS > LEN_W) ? CSR_BITS : LEN_W;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]        pos_ff, pos_in;
   logic [LEN_W-1:0]        pos_next;
   logic [CW-1:0]           count_ext;

   // Zero length counts as one, anything beyond the maximum saturates.
   always_comb begin
      count_ext = CW'(count_reg);
      if (count_ext == '0) begin
         len = LEN_W'(1);
      end else if (count_ext > CW'(MAX_LEN)) begin
         len = LEN_W'(MAX_LEN);
      end else begin
         len = LEN_W'(count_ext);
      end
   end

   assign pos_next  = pos_ff + LEN_W'(1);
   assign sum_total = sum_ff + SUM_W'(sample);
   assign slice_end = accept && (pos_next >= len);

   always_comb begin
      sum_in = sum_ff;
      pos_in = pos_ff;
      if (accept) begin
         if (slice_end) begin
            sum_in = '0;
            pos_in = '0;
         end else begin
            sum_in = sum_total;
            pos_in = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         pos_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: sv/gap_div.sv
`timescale 1ns / 1ps
// Iterative signed divider: one quotient bit per cycle, restoring scheme,
// truncates toward zero. Depends on gap_pkg.
module gap_div #(
   parameter int SUM_W = 33,
   parameter int LEN_W = 17,
   parameter int OUT_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gap_pkg::div_ctl_type    ctl,
   input  logic signed [SUM_W-1:0] sum,
   input  logic [LEN_W-1:0]        len,
   output gap_pkg::div_stat_type   stat,
   output logic signed [OUT_W-1:0] average
);
   import gap_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   div_state_type    state_ff, state_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W:0]   shifted;
   logic [LEN_W:0]   diff;
   logic             fits;
   logic [SUM_W-1:0] mag;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               state_in = DIV_ABS;
            end
         end
         DIV_ABS:  state_in = DIV_RUN;
         DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = DIV_HOLD;
            end
         end
         DIV_HOLD: begin
            if (ctl.out_free) begin
               state_in = DIV_IDLE;
            end
         end
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      stat.idle = (state_ff == DIV_IDLE);
      stat.done = (state_ff == DIV_HOLD) && ctl.out_free;
   end

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               quo_in = sum;
               neg_in = sum[SUM_W-1];
               div_in = len;
               rem_in = '0;
               cnt_in = CNT_W'(SUM_W - 1);
            end
         end
         DIV_ABS: begin
            // work on the magnitude, restore the sign at the end
            if (neg_ff) begin
               quo_in = -quo_ff;
            end
         end
         DIV_RUN: begin
            rem_in = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], fits};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: begin
            quo_in = quo_ff;
         end
      endcase
   end

   assign mag     = neg_ff ? -quo_ff : quo_ff;
   assign average = OUT_W'(mag[OUT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   a_start_when_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == DIV_IDLE)
      else $error("divider started while busy");

   a_start_to_abs : assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == DIV_IDLE) |=> state_ff == DIV_ABS)
      else $error("divider did not take the start");

   a_rem_below_div : assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN |-> div_ff != '0)
      else $error("divider running with a zero divisor");

endmodule

FILE: sv/global_average_pool.sv
`timescale 1ns / 1ps
// Global average pooling over a stream of signed samples.
//
// req_chan carries one sample per transfer; slices of spatial_count samples
// follow one another. rsp_chan carries one average per slice: the slice sum
// divided by the slice length, truncated toward zero. csr_wr_en/csr_wr_data
// write spatial_count (0 acts as 1, values above MAX_SLICE_LENGTH saturate);
// write it only while the block is idle.
//
// Samples inside a slice are taken one per cycle. The last sample of a slice
// starts the divider: a set-up step takes the magnitude of the sum, then it
// produces one quotient bit per cycle (SAMPLE_BITS + clog2(MAX_SLICE_LENGTH+1)
// bits in all), then a hand-over step waits until the result register is free.
// req_chan.ready is low until the divider is idle again.
// The average appears on rsp_chan the cycle after the divider finishes.
// While rsp_chan is stalled the result register holds its value, samples of
// the next slice are still taken, and a further finished division waits in
// the divider. Reset clears the sum, the position, the divider state and the
// output valid flag, and sets spatial_count to 1.
// Depends on gap_pkg, gap_req_if, gap_rsp_if, gap_acc and gap_div.
module global_average_pool #(
   parameter int MAX_SLICE_LENGTH = 65536,
   parameter int SAMPLE_BITS      = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   gap_req_if.sink                      req_chan,
   gap_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [gap_pkg::CSR_BITS-1:0] csr_wr_data
);
   import gap_pkg::*;

   localparam int LEN_W = $clog2(MAX_SLICE_LENGTH + 1);
   localparam int SUM_W = SAMPLE_BITS + LEN_W;

   logic [CSR_BITS-1:0]           count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                          accept;
   logic                          slice_end;
   logic signed [SUM_W-1:0]       sum_total;
   logic [LEN_W-1:0]              len;
   logic signed [SAMPLE_BITS-1:0] div_average;
   div_ctl_type                   div_ctl;
   div_stat_type                  div_stat;

   assign req_chan.ready = div_stat.idle;
   assign accept         = req_chan.valid && req_chan.ready;

   gap_acc #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_LEN     (MAX_SLICE_LENGTH),
      .LEN_W       (LEN_W),
      .SUM_W       (SUM_W)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_chan.sample),
      .count_reg (count_ff),
      .slice_end (slice_end),
      .sum_total (sum_total),
      .len       (len)
   );

   always_comb begin
      div_ctl.start    = slice_end;
      div_ctl.out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   gap_div #(
      .SUM_W (SUM_W),
      .LEN_W (LEN_W),
      .OUT_W (SAMPLE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .sum     (sum_total),
      .len     (len),
      .stat    (div_stat),
      .average (div_average)
   );

   // Load on a finished division, drop once the transfer completes.
   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      avg_in       = div_stat.done ? div_average : avg_ff;
      rsp_valid_in = rsp_valid_ff;
      if (div_stat.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.average = avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CSR_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

endmodule

FILE: dv/gap_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the global average pooling block: tracks slice sums, predicts averages.
// Depends on gap_pkg, gap_req_if and gap_rsp_if.
module gap_checker #(
   parameter int MAX_LEN     = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   gap_req_if                           req_chan,
   gap_rsp_if                           rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [gap_pkg::CSR_BITS-1:0] csr_wr_data,
   output int                           fail_count,
   output int                           pending_count,
   output int                           averages_checked
);

   logic [gap_pkg::CSR_BITS-1:0]  slice_len_reg;
   longint                        slice_sum;
   longint                        slice_taken;
   logic signed [SAMPLE_BITS-1:0] averages_due [$];

   // Zero acts as one, anything past the maximum saturates.
   function automatic longint slice_length(input logic [gap_pkg::CSR_BITS-1:0] reg_value);
      if (reg_value == 0) return 1;
      if (reg_value > MAX_LEN) return MAX_LEN;
      return longint'(reg_value);
   endfunction

   always @(posedge clock) begin : track
      logic signed [SAMPLE_BITS-1:0] due;
      longint                        divisor;
      longint                        quotient;
      if (reset) begin
         slice_len_reg = 1;
         slice_sum     = 0;
         slice_taken   = 0;
         averages_due.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            divisor = slice_length(slice_len_reg);
            slice_sum += req_chan.sample;
            slice_taken++;
            // A shortened length ends the slice on the next sample.
            if (slice_taken >= divisor) begin
               quotient = slice_sum / divisor;
               averages_due.push_back(quotient[SAMPLE_BITS-1:0]);
               slice_sum   = 0;
               slice_taken = 0;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (averages_due.size() == 0) begin
               fail_count++;
               $display("%0t: average %0d with no slice ended", $time, rsp_chan.average);
            end else begin
               due = averages_due.pop_front();
               averages_checked++;
               if (rsp_chan.average !== due) begin
                  fail_count++;
                  $display("%0t: average expected %0d, got %0d", $time, due,
                           rsp_chan.average);
               end
            end
         end
         if (csr_wr_en) slice_len_reg = csr_wr_data;
      end
      pending_count = averages_due.size();
   end

endmodule

FILE: dv/tb_global_average_pool.sv
`timescale 1ns / 1ps
// Top of the pooling testbench: clock, reset, sample and length stimulus, verdict.
// Depends on gap_pkg, gap_req_if, gap_rsp_if, gap_checker and global_average_pool.
module tb_global_average_pool;
   import gap_pkg::*;

   localparam int MAX_LEN      = 65536;
   localparam int SAMPLE_BITS  = 16;
   localparam int DIV_LATENCY  = 40;
   localparam int QUIET_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 1780;
   localparam int SAT_ITEMS    = 100;

   typedef enum int {MIX_FULL, MIX_HIGH, MIX_LOW, MIX_TINY} sample_mix_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   logic [gap_pkg::CSR_BITS-1:0] csr_wr_data;
   int                           fail_count;
   int                           pending_count;
   int                           averages_checked;
   int                           samples_sent = 0;
   int                           burst_left   = 0;
   int                           gap_max      = 4;
   int                           quiet_cycles = 0;
   int                           stall_tick   = 0;
   logic [7:0]                   stall_mask   = '1;

   gap_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   gap_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();

   global_average_pool #(
      .MAX_SLICE_LENGTH(MAX_LEN),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   gap_checker #(
      .MAX_LEN    (MAX_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .averages_checked(averages_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver: a fresh ready mask each time stall_tick runs out, fully open a quarter of the time.
   always @(negedge clock) begin
      if (stall_tick == 0) begin
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom());
         stall_tick = 64;
      end
      stall_tick--;
      rsp_chan.ready = stall_mask[stall_tick % 8];
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_wr_en)
      begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_mix_type mix);
      case (mix)
         MIX_HIGH: return 16'(32767 - $urandom_range(0, 15));
         MIX_LOW:  return 16'(32'h8000 + $urandom_range(0, 15));
         MIX_TINY: return 16'($urandom_range(0, 16) - 8);
         default:  return 16'($urandom());
      endcase
   endfunction

   // Hold the sample until its transfer, with a random gap between bursts.
   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid  = 1'b1;
      req_chan.sample = value;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // Write the length only once every average is out and the divider has drained.
   task automatic set_slice_length(input logic [gap_pkg::CSR_BITS-1:0] value);
      req_chan.valid = 1'b0;
      burst_left     = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DIV_LATENCY) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      int             len;
      int             eff;
      int             count;
      int             pick;
      int             random_items;
      int             settings;
      sample_mix_type mix;
      random_items    = 0;
      settings        = 0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset length of one: every sample is its own average.
      push_sample(16'sd0);
      push_sample(16'sd32767);
      push_sample(-16'sd32768);
      push_sample(16'sd1);
      push_sample(-16'sd1);
      // Zero length acts as one.
      set_slice_length(CSR_BITS'(0));
      push_sample(16'sd12345);
      push_sample(-16'sd2);
      set_slice_length(CSR_BITS'(2));
      push_sample(16'sd32767);
      push_sample(16'sd32767);
      push_sample(-16'sd32768);
      push_sample(-16'sd32768);
      push_sample(-16'sd3);
      push_sample(16'sd0);
      push_sample(16'sd3);
      push_sample(16'sd0);
      push_sample(-16'sd32768);
      push_sample(16'sd32767);
      // Shorten the length mid-slice: the next sample closes it.
      set_slice_length(CSR_BITS'(3));
      push_sample(-16'sd7);
      push_sample(-16'sd1);
      set_slice_length(CSR_BITS'(2));
      push_sample(-16'sd1);
      settings = 4;

      // Saturated length: open a long slice, then close it early with a length of one.
      set_slice_length(17'h1ffff);
      settings++;
      gap_max = 1;
      repeat (SAT_ITEMS) push_sample(-16'sd32768);
      set_slice_length(CSR_BITS'(1));
      settings++;
      push_sample(-16'sd32768);

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) len = 0;
         else if (pick < 50) len = $urandom_range(1, 4);
         else if (pick < 80) len = $urandom_range(5, 16);
         else if (pick < 96) len = $urandom_range(17, 64);
         else len = $urandom_range(65, 300);
         eff = (len == 0) ? 1 : len;
         set_slice_length(CSR_BITS'(len));
         settings++;
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         mix     = sample_mix_type'($urandom_range(0, 3));
         count   = $urandom_range(1, 4) * eff;
         // Leave a slice open now and then so the next length lands mid-slice.
         if (eff > 1 && $urandom_range(0, 2) == 0) count += $urandom_range(1, eff - 1);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         repeat (count) push_sample(pick_sample(mix));
         random_items += count;
      end

      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DIV_LATENCY) @(posedge clock);
      $display("Sent %0d samples under %0d slice lengths, %0d averages checked.",
               samples_sent, settings, averages_checked);
      $display("Lengths covered zero, one, short, mid-slice changes and a saturated maximum.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
